### sv/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds command codes, status codes and the controller state type.
// No dependencies.
package dq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

endpackage

### sv/dq_ram.sv
// Word store of the deque: one write port, one read port, registered read.
// Depends on dq_pkg for the word width.
module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [PW-1:0]            waddr,
    input  logic signed [WORD_W-1:0] wdata,
    input  logic [PW-1:0]            raddr,
    output logic signed [WORD_W-1:0] rdata
);

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/dq_ctrl.sv
// Deque controller: front pointer, count, cached end words and command sequencing.
// Depends on dq_pkg; drives the word store in dq_ram.
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               cmd,
    input  logic signed [WORD_W-1:0] push_word,
    output logic                     busy,
    output logic                     done,
    output logic signed [WORD_W-1:0] popped_word,
    output logic [1:0]               status,
    output logic [CW-1:0]            occupancy,
    output logic signed [WORD_W-1:0] front_word,
    output logic signed [WORD_W-1:0] back_word,
    output logic                     mem_we,
    output logic [PW-1:0]            mem_waddr,
    output logic signed [WORD_W-1:0] mem_wdata,
    output logic [PW-1:0]            mem_raddr,
    input  logic signed [WORD_W-1:0] mem_rdata
);

    state_t                   state_reg, state_next;
    logic [PW-1:0]            fp_reg, fp_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [WORD_W-1:0] front_reg, front_next;
    logic signed [WORD_W-1:0] back_reg, back_next;
    logic                     fill_front_reg, fill_front_next;
    logic                     done_reg, done_next;
    logic signed [WORD_W-1:0] popped_reg, popped_next;
    status_t                  status_reg, status_next;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          needs_fetch;
    logic [PW-1:0] fp_dec;
    logic [PW-1:0] fp_inc;
    logic [PW-1:0] tail_idx;
    logic [PW-1:0] back2_idx;

    function automatic logic [PW-1:0] wrap_idx(input logic [PW:0] s);
        logic [PW:0] t;
        t = (s >= (PW+1)'(DEPTH)) ? s - (PW+1)'(DEPTH) : s;
        return t[PW-1:0];
    endfunction

    assign accept   = start && (state_reg == S_IDLE);
    assign is_full  = (cnt_reg == CW'(DEPTH));
    assign is_empty = (cnt_reg == '0);

    assign fp_dec    = (fp_reg == '0) ? PW'(DEPTH - 1) : fp_reg - PW'(1);
    assign fp_inc    = (fp_reg == PW'(DEPTH - 1)) ? '0 : fp_reg + PW'(1);
    assign tail_idx  = wrap_idx({1'b0, fp_reg} + (PW+1)'(cnt_reg));
    assign back2_idx = wrap_idx({1'b0, fp_reg} + (PW+1)'(cnt_reg) - (PW+1)'(2));

    // a pop that leaves one or more words must refill one cached end
    assign needs_fetch = accept && cmd[1] && (cnt_reg > CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = needs_fetch ? S_FETCH : S_IDLE;
            S_FETCH: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        busy = 1'b0;
        case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_FETCH: busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        fp_next         = fp_reg;
        cnt_next        = cnt_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        fill_front_next = fill_front_reg;
        done_next       = 1'b0;
        popped_next     = popped_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = tail_idx;
        mem_wdata       = push_word;
        mem_raddr       = fp_inc;

        if (state_reg == S_FETCH)
        begin
            if (fill_front_reg)
            begin
                front_next = mem_rdata;
            end
            else
            begin
                back_next = mem_rdata;
            end
            done_next = 1'b1;
        end
        else if (accept)
        begin
            popped_next = '0;
            status_next = ST_OK;
            done_next   = !needs_fetch;
            case (cmd_t'(cmd))
                CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        fp_next    = fp_dec;
                        cnt_next   = cnt_reg + CW'(1);
                        mem_we     = 1'b1;
                        mem_waddr  = fp_dec;
                        front_next = push_word;
                        if (is_empty)
                        begin
                            back_next = push_word;
                        end
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + CW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = tail_idx;
                        back_next = push_word;
                        if (is_empty)
                        begin
                            front_next = push_word;
                        end
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        popped_next     = front_reg;
                        fp_next         = fp_inc;
                        cnt_next        = cnt_reg - CW'(1);
                        mem_raddr       = fp_inc;
                        fill_front_next = 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        popped_next     = back_reg;
                        cnt_next        = cnt_reg - CW'(1);
                        mem_raddr       = back2_idx;
                        fill_front_next = 1'b0;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fp_reg    <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fp_reg    <= fp_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        fill_front_reg <= fill_front_next;
        popped_reg     <= popped_next;
        status_reg     <= status_next;
    end

    assign done        = done_reg;
    assign popped_word = popped_reg;
    assign status      = status_reg;
    assign occupancy   = cnt_reg;
    assign front_word  = is_empty ? '0 : front_reg;
    assign back_word   = is_empty ? '0 : back_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_fp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fp_reg <= PW'(DEPTH - 1))
        else $error("front pointer out of range");

    a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> done_reg)
        else $error("refill did not deliver a result");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !needs_fetch |=> done_reg && state_reg == S_IDLE)
        else $error("command without refill must finish in one cycle");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_EMPTY |-> cnt_reg == '0)
        else $error("empty error with words held");

endmodule

### sv/double_ended_queue.sv
// Double-ended queue of signed 32-bit words in a ring buffer of DEPTH entries.
// A command is taken at a rising edge where start is high and busy is low. Each
// command gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall it, so capture it when done is seen. Pushes, refused
// commands, and pops that empty the deque need no fetch; done follows in the
// cycle after the command is taken, and the next command may follow at once.
// A pop that leaves one or more words passes through a fetch state: the word
// store has one registered read port, and the new front or back word is fetched
// through it while busy is high. No clearing pass is needed after reset.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               cmd,
    input  logic signed [WORD_W-1:0] push_word,
    output logic                     done,
    output logic signed [WORD_W-1:0] popped_word,
    output logic [1:0]               status,
    output logic [CW-1:0]            occupancy,
    output logic signed [WORD_W-1:0] front_word,
    output logic signed [WORD_W-1:0] back_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // memory port between controller and word store
    logic                     mem_we;
    logic [PW-1:0]            mem_waddr;
    logic signed [WORD_W-1:0] mem_wdata;
    logic [PW-1:0]            mem_raddr;
    logic signed [WORD_W-1:0] mem_rdata;

    // hold pointer, count and cached end words; sequence each command
    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .push_word   (push_word),
        .busy        (busy),
        .done        (done),
        .popped_word (popped_word),
        .status      (status),
        .occupancy   (occupancy),
        .front_word  (front_word),
        .back_word   (back_word),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // store every word held; read data is registered and lands in the cycle after the address
    dq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

### bench/testbench.sv
// Self-checking bench for the double_ended_queue block.
// Depends on dq_pkg (command and status codes, DEPTH_DEF, WORD_W) and the RTL.
// Every accepted command is replayed on a behavioral ring buffer.
module testbench;
    import dq_pkg::*;

    localparam int QDEPTH    = DEPTH_DEF;
    localparam int IW        = $clog2(QDEPTH);
    localparam int CW        = $clog2(QDEPTH + 1);
    localparam int RAND_CMDS = 1250;
    // Hang limit: the slowest correct run, every command refilling plus the
    // longest sender gap, taken several times over.
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        status_t                  st;
        logic [CW-1:0]            occ;
        logic signed [WORD_W-1:0] front;
        logic signed [WORD_W-1:0] back;
    } deque_result_t;

    typedef struct {
        cmd_t              op;
        logic [WORD_W-1:0] word;
        bit                pinned;
        deque_result_t     want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               cmd;
    logic signed [WORD_W-1:0] push_word;
    logic                     done;
    logic signed [WORD_W-1:0] popped_word;
    logic [1:0]               status;
    logic [CW-1:0]            occupancy;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;

    // Behavioral copy of the deque state.
    logic [WORD_W-1:0] ring [QDEPTH];
    logic [IW-1:0]     ring_head;
    logic [CW-1:0]     ring_count;

    // Results still owed by the block, oldest first.
    deque_result_t awaited_results[$];
    stim_row_t     directed_rows[$];

    // Hand-typed expectation that rides along with the word being driven.
    bit            pin_on;
    deque_result_t pin_want;

    int mismatches;
    int cycle_count;
    int push_bias;

    double_ended_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .push_word   (push_word),
        .done        (done),
        .popped_word (popped_word),
        .status      (status),
        .occupancy   (occupancy),
        .front_word  (front_word),
        .back_word   (back_word)
    );

    always #5 clk = ~clk;

    // Apply one command to the ring copy and return the result it must give.
    function automatic deque_result_t deque_apply(cmd_t op, logic [WORD_W-1:0] w);
        deque_result_t r;
        logic [IW-1:0] slot;
        r = '0;
        r.st = ST_OK;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (ring_count == QDEPTH)
                    r.st = ST_FULL;      // drop the word, keep the state
                else if (op == CMD_PUSH_FRONT)
                begin
                    ring_head = ring_head - 1'b1;
                    ring[ring_head] = w;
                    ring_count = ring_count + 1'b1;
                end
                else
                begin
                    slot = ring_head + ring_count[IW-1:0];
                    ring[slot] = w;
                    ring_count = ring_count + 1'b1;
                end
            end
            default:
            begin
                if (ring_count == 0)
                    r.st = ST_EMPTY;
                else if (op == CMD_POP_FRONT)
                begin
                    r.popped = ring[ring_head];
                    ring_head = ring_head + 1'b1;
                    ring_count = ring_count - 1'b1;
                end
                else
                begin
                    slot = ring_head + ring_count[IW-1:0] - 1'b1;
                    r.popped = ring[slot];
                    ring_count = ring_count - 1'b1;
                end
            end
        endcase
        r.occ = ring_count;
        // Front and back read as zero once the deque is empty.
        if (ring_count != 0)
        begin
            slot = ring_head + ring_count[IW-1:0] - 1'b1;
            r.front = ring[ring_head];
            r.back = ring[slot];
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // Score the result strobe first, then log a newly accepted command.
    // Both read pre-edge values, so the order inside the step does not matter.
    always @(posedge clk)
    begin : scoreboard
        deque_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result strobe with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("popped_word", want.popped, popped_word);
                    compare_field("status", want.st, status);
                    compare_field("occupancy", want.occ, occupancy);
                    compare_field("front_word", want.front, front_word);
                    compare_field("back_word", want.back, back_word);
                end
            end
            if (start && !busy)
            begin
                want = deque_apply(cmd_t'(cmd), push_word);
                // A typed-in row overrides the predictor, which still advances.
                awaited_results.push_back(pin_on ? pin_want : want);
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one word at the falling edge and hold it until busy is low
    // at a rising edge.
    task automatic send_word(cmd_t op, logic [WORD_W-1:0] w, bit pin,
                             deque_result_t want);
        @(negedge clk);
        start = 1'b1;
        cmd = op;
        push_word = w;
        pin_on = pin;
        pin_want = want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start while idling; scramble the payload to prove it is ignored.
    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
            cmd = 2'($urandom);
            push_word = $urandom;
        end
    endtask

    function automatic void add_row(cmd_t op, logic [WORD_W-1:0] w, bit pinned,
                                    logic [WORD_W-1:0] p, status_t s,
                                    logic [CW-1:0] o, logic [WORD_W-1:0] f,
                                    logic [WORD_W-1:0] b);
        stim_row_t row;
        row.op = op;
        row.word = w;
        row.pinned = pinned;
        row.want = '{popped: p, st: s, occ: o, front: f, back: b};
        directed_rows.push_back(row);
    endfunction

    // Full-range random words half the time, the extremes the other half.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        cmd_t op;
        int   burst;
        int   sent;
        bit   drained;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_PUSH_FRONT;
        push_word = '0;
        pin_on = 1'b0;
        pin_want = '0;
        mismatches = 0;
        cycle_count = 0;
        ring_head = '0;
        ring_count = '0;
        foreach (ring[i])
            ring[i] = '0;

        // Directed rows: empty pops with a junk word, the signed extremes at both
        // ends, wrap below index zero, fill until full and refuse, pop each end.
        add_row(CMD_POP_FRONT, 32'hdead_beef, 1, 0, ST_EMPTY, 0, 0, 0);
        add_row(CMD_POP_BACK, 32'hffff_ffff, 1, 0, ST_EMPTY, 0, 0, 0);
        add_row(CMD_PUSH_BACK, 32'h7fff_ffff, 1, 0, ST_OK, 1,
                32'h7fff_ffff, 32'h7fff_ffff);
        add_row(CMD_PUSH_FRONT, 32'h8000_0000, 1, 0, ST_OK, 2,
                32'h8000_0000, 32'h7fff_ffff);
        add_row(CMD_POP_BACK, 32'h1234_5678, 1, 32'h7fff_ffff, ST_OK, 1,
                32'h8000_0000, 32'h8000_0000);
        add_row(CMD_POP_FRONT, 32'h0, 1, 32'h8000_0000, ST_OK, 0, 0, 0);
        add_row(CMD_PUSH_FRONT, 32'hffff_ffff, 1, 0, ST_OK, 1,
                32'hffff_ffff, 32'hffff_ffff);
        for (int i = 1; i < QDEPTH; i++)
            add_row(CMD_PUSH_BACK, i, 0, 0, ST_OK, 0, 0, 0);
        add_row(CMD_PUSH_BACK, 32'h5555_5555, 1, 0, ST_FULL, CW'(QDEPTH),
                32'hffff_ffff, QDEPTH - 1);
        add_row(CMD_PUSH_FRONT, 32'haaaa_aaaa, 1, 0, ST_FULL, CW'(QDEPTH),
                32'hffff_ffff, QDEPTH - 1);
        add_row(CMD_POP_BACK, 32'h0, 0, 0, ST_OK, 0, 0, 0);
        add_row(CMD_POP_FRONT, 32'h0, 0, 0, ST_OK, 0, 0, 0);

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].word,
                      directed_rows[i].pinned, directed_rows[i].want);

        // Random bursts. The push share swings between low and high so the
        // deque keeps running into both the empty and the full wall.
        sent = 0;
        drained = 1'b0;
        push_bias = 50;
        while (sent < RAND_CMDS)
        begin
            if ($urandom_range(0, 3) == 0)
                case ($urandom_range(0, 3))
                    0: push_bias = 15;
                    1: push_bias = 85;
                    default: push_bias = 50;
                endcase
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < push_bias)
                    op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                send_word(op, pick_word(), 0, '0);
                sent++;
            end
            // Leave about a third of the bursts back to back.
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 6));
            // Hold off once until every owed result is back.
            if (!drained && sent >= RAND_CMDS / 2)
            begin
                idle_cycles(1);
                while (awaited_results.size() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
        end

        idle_cycles(1);
        while (awaited_results.size() != 0)
            @(posedge clk);
        // Give a stray strobe a chance to show up.
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### double_ended_queue.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_ctrl.sv
sv/double_ended_queue.sv
bench/testbench.sv
